// File: rtl/sobs_pkg.sv
// Shared types and constants for the set of bounded stacks block.
`timescale 1ns / 1ps

package sobs_pkg;

  localparam int SUBSTACK_DEPTH = 3;
  localparam int MAX_SUBSTACKS  = 16;

  localparam int KIND_W = 2;
  localparam int WORD_W = 32;
  localparam int TGT_W  = 4;
  localparam int STAT_W = 2;
  localparam int LIVE_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 2'd0,
    KIND_POP_LAST = 2'd1,
    KIND_POP_AT   = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic              pop;
    status_e           status;
    logic [LIVE_W-1:0] live;
  } meta_t;

endpackage

// File: rtl/sobs_word_ram.sv
// Word memory of the substacks: one shared port, registered read data.
`timescale 1ns / 1ps

module sobs_word_ram #(
  parameter int Depth  = 48,
  parameter int AddrW  = 6,
  parameter int WordW  = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WordW-1:0] wdata_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem [Depth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sobs_ctrl.sv
// Substack order row, fill counts and live count, with the per-item update.
`timescale 1ns / 1ps

module sobs_ctrl #(
  parameter int SubstackDepth = sobs_pkg::SUBSTACK_DEPTH,
  parameter int MaxSubstacks  = sobs_pkg::MAX_SUBSTACKS,
  parameter int AddrW         = $clog2(SubstackDepth * MaxSubstacks)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            exec_en_i,
  input  logic [sobs_pkg::KIND_W-1:0]     kind_i,
  input  logic [sobs_pkg::TGT_W-1:0]      target_i,
  output logic                            wr_en_o,
  output logic [AddrW-1:0]                addr_o,
  output sobs_pkg::meta_t                 meta_o
);

  localparam int FillW = $clog2(SubstackDepth + 1);
  localparam int SlotW = $clog2(MaxSubstacks);
  localparam int CntW  = $clog2(MaxSubstacks + 1);
  localparam int CmpW  = (CntW > sobs_pkg::TGT_W) ? CntW : sobs_pkg::TGT_W;

  logic [SlotW-1:0] order_q [MaxSubstacks];
  logic [SlotW-1:0] order_d [MaxSubstacks];
  logic [FillW-1:0] fill_q  [MaxSubstacks];
  logic [FillW-1:0] fill_d  [MaxSubstacks];
  logic [CntW-1:0]  total_q;
  logic [CntW-1:0]  total_d;

  logic             total_zero;
  logic             full;
  logic             opened;
  logic             tgt_ok;
  logic             is_at;
  logic [CntW-1:0]  last;
  logic [SlotW-1:0] last_pos;
  logic [SlotW-1:0] tgt_pos;
  logic [SlotW-1:0] new_pos;
  logic [SlotW-1:0] fill_pos;
  logic [SlotW-1:0] slot_pos;
  logic [SlotW-1:0] slot;
  logic [FillW-1:0] fill_rd;
  logic [FillW-1:0] fill_dec;
  logic [CmpW-1:0]  tgt_ext;
  logic [CmpW-1:0]  tot_ext;
  logic [AddrW-1:0] base;

  always_comb begin
    total_zero = (total_q == '0);
    full       = (total_q == CntW'(MaxSubstacks));
    last       = total_q - 1'b1;
    last_pos   = total_zero ? '0 : last[SlotW-1:0];
    tgt_ext    = CmpW'(target_i);
    tot_ext    = CmpW'(total_q);
    tgt_ok     = (tgt_ext < tot_ext);
    tgt_pos    = tgt_ok ? tgt_ext[SlotW-1:0] : '0;
    is_at      = (kind_i == sobs_pkg::KIND_POP_AT);
    fill_pos   = is_at ? tgt_pos : last_pos;
    fill_rd    = fill_q[fill_pos];
    fill_dec   = fill_rd - 1'b1;
    opened     = total_zero || (fill_rd == FillW'(SubstackDepth));
    new_pos    = full ? '0 : total_q[SlotW-1:0];
    slot_pos   = ((kind_i == sobs_pkg::KIND_PUSH) && opened) ? new_pos : fill_pos;
    slot       = order_q[slot_pos];
    base       = AddrW'(slot) * AddrW'(SubstackDepth);

    total_d = total_q;
    order_d = order_q;
    fill_d  = fill_q;
    wr_en_o = 1'b0;
    addr_o  = base;
    meta_o.pop    = 1'b0;
    meta_o.status = sobs_pkg::ST_DONE;

    unique case (kind_i)
      sobs_pkg::KIND_PUSH: begin
        if (opened && full) begin
          meta_o.status = sobs_pkg::ST_FULL;
        end else begin
          wr_en_o = exec_en_i;
          addr_o  = base + (opened ? '0 : AddrW'(fill_rd));
          fill_d[slot_pos] = opened ? FillW'(1) : fill_rd + 1'b1;
          if (opened) begin
            total_d = total_q + 1'b1;
          end
        end
      end
      sobs_pkg::KIND_POP_LAST, sobs_pkg::KIND_POP_AT: begin
        if (is_at ? !tgt_ok : total_zero) begin
          meta_o.status = sobs_pkg::ST_EMPTY;
        end else begin
          meta_o.pop = 1'b1;
          addr_o     = base + AddrW'(fill_dec);
          if (fill_dec != '0) begin
            fill_d[fill_pos] = fill_dec;
          end else begin
            for (int i = 0; i < MaxSubstacks; i++) begin
              if (SlotW'(i) >= fill_pos) begin
                if (i == MaxSubstacks - 1) begin
                  order_d[i] = slot;
                  fill_d[i]  = '0;
                end else begin
                  order_d[i] = order_q[i+1];
                  fill_d[i]  = fill_q[i+1];
                end
              end
            end
            total_d = total_q - 1'b1;
          end
        end
      end
      default: begin
        meta_o.status = sobs_pkg::ST_EMPTY;
      end
    endcase

    meta_o.live = sobs_pkg::LIVE_W'(total_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < MaxSubstacks; i++) begin
        order_q[i] <= SlotW'(i);
        fill_q[i]  <= '0;
      end
    end else if (exec_en_i) begin
      total_q <= total_d;
      order_q <= order_d;
      fill_q  <= fill_d;
    end
  end

endmodule

// File: rtl/set_of_bounded_stacks_core.sv
// Top level of the set of bounded stacks: input, update and result stages.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o    | kind_i, push_value_i, target_index_i
//   out     | output    | out_valid_o / out_stall_i  | pop_value_o, status_o, live_substacks_o
//
// One beat per cycle unless out stalls; a beat passes the in, update and result stages.
// The word memory has a single port with registered read data, which sets the three stages.
// Reset empties every substack and restores the slot order; word memory is not cleared.
// A stall on out holds every stage that cannot advance and backs up onto in_stall_o.
`timescale 1ns / 1ps

module set_of_bounded_stacks_core #(
  parameter int SubstackDepth = sobs_pkg::SUBSTACK_DEPTH,
  parameter int MaxSubstacks  = sobs_pkg::MAX_SUBSTACKS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sobs_pkg::KIND_W-1:0]       kind_i,
  input  logic signed [sobs_pkg::WORD_W-1:0] push_value_i,
  input  logic [sobs_pkg::TGT_W-1:0]        target_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sobs_pkg::WORD_W-1:0] pop_value_o,
  output logic [sobs_pkg::STAT_W-1:0]       status_o,
  output logic [sobs_pkg::LIVE_W-1:0]       live_substacks_o
);

  localparam int StoreWords = SubstackDepth * MaxSubstacks;
  localparam int AddrW      = $clog2(StoreWords);

  logic                          in_vld_q;
  logic [sobs_pkg::KIND_W-1:0]   kind_q;
  logic [sobs_pkg::WORD_W-1:0]   value_q;
  logic [sobs_pkg::TGT_W-1:0]    tgt_q;

  logic                          mid_vld_q;
  sobs_pkg::meta_t               meta_d;
  sobs_pkg::meta_t               meta_q;

  logic                          out_vld_q;
  logic [sobs_pkg::WORD_W-1:0]   pop_value_q;
  logic [sobs_pkg::STAT_W-1:0]   status_q;
  logic [sobs_pkg::LIVE_W-1:0]   live_q;

  logic                          out_go;
  logic                          mid_go;
  logic                          in_go;
  logic                          exec_en;
  logic                          wr_en;
  logic [AddrW-1:0]              addr;
  logic [sobs_pkg::WORD_W-1:0]   rdata;

  assign out_go  = !out_vld_q || !out_stall_i;
  assign mid_go  = !mid_vld_q || out_go;
  assign in_go   = !in_vld_q || mid_go;
  assign exec_en = in_vld_q && mid_go;

  sobs_ctrl #(
    .SubstackDepth (SubstackDepth),
    .MaxSubstacks  (MaxSubstacks),
    .AddrW         (AddrW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .exec_en_i (exec_en),
    .kind_i    (kind_q),
    .target_i  (tgt_q),
    .wr_en_o   (wr_en),
    .addr_o    (addr),
    .meta_o    (meta_d)
  );

  sobs_word_ram #(
    .Depth (StoreWords),
    .AddrW (AddrW),
    .WordW (sobs_pkg::WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .wr_en_i (wr_en),
    .rd_en_i (mid_go),
    .addr_i  (addr),
    .wdata_i (value_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_go) begin
        in_vld_q <= in_valid_i;
      end
      if (mid_go) begin
        mid_vld_q <= in_vld_q;
      end
      if (out_go) begin
        out_vld_q <= mid_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go && in_valid_i) begin
      kind_q  <= kind_i;
      value_q <= push_value_i;
      tgt_q   <= target_index_i;
    end
    if (mid_go) begin
      meta_q <= meta_d;
    end
    if (out_go && mid_vld_q) begin
      pop_value_q <= meta_q.pop ? rdata : '0;
      status_q    <= meta_q.status;
      live_q      <= meta_q.live;
    end
  end

  assign in_stall_o       = !in_go;
  assign out_valid_o      = out_vld_q;
  assign pop_value_o      = pop_value_q;
  assign status_o         = status_q;
  assign live_substacks_o = live_q;

endmodule
